>>> design/xtea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XTEA package
// Shared constants, register codes and round helper functions.
// ----------------------------------------------------------------------------
package xtea_pkg;

    localparam int unsigned ROUNDS    = 32;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned KEY_WORDS = 4;
    localparam int unsigned SUM_SHIFT = 11;
    localparam int unsigned ADDR_W    = 4;
    localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

    typedef logic [WORD_W-1:0] t_word;

    // key register codes, paddr[3:2]
    typedef enum logic [1:0] {
        REG_KEY0 = 2'd0,
        REG_KEY1 = 2'd1,
        REG_KEY2 = 2'd2,
        REG_KEY3 = 2'd3
    } t_reg_idx;

    // running sum after n rounds, modulo 2^32
    function automatic t_word round_sum(input int unsigned n);
        t_word acc;
        acc = '0;
        for (int unsigned i = 0; i < n; i++) begin
            acc = acc + DELTA;
        end
        return acc;
    endfunction

    // key word used by the left half-round
    function automatic t_reg_idx left_key_idx(input t_word s);
        return t_reg_idx'(s[1:0]);
    endfunction

    // key word used by the right half-round
    function automatic t_reg_idx right_key_idx(input t_word s);
        return t_reg_idx'(s[SUM_SHIFT+1:SUM_SHIFT]);
    endfunction

    function automatic t_word mix_word(input t_word w);
        return ((w << 4) ^ (w >> 5)) + w;
    endfunction

endpackage
`default_nettype wire

>>> design/xtea_half_round.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XTEA half-round stage
// One registered Feistel half-round: updates either the left or right word.
// ----------------------------------------------------------------------------
module xtea_half_round #(
    parameter xtea_pkg::t_word SUM          = '0,
    parameter bit              UPDATE_RIGHT = 1'b0
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_adv,
    input  wire logic            i_valid,
    input  wire xtea_pkg::t_word i_left,
    input  wire xtea_pkg::t_word i_right,
    input  wire xtea_pkg::t_word i_key,
    output logic                 o_valid,
    output xtea_pkg::t_word      o_left,
    output xtea_pkg::t_word      o_right
);

    logic            r_valid;
    xtea_pkg::t_word r_left, r_right;
    xtea_pkg::t_word n_left, n_right;
    xtea_pkg::t_word w_src, w_mix;

    always_comb begin
        w_src   = UPDATE_RIGHT ? i_left : i_right;
        w_mix   = xtea_pkg::mix_word(w_src) ^ (SUM + i_key);
        n_left  = UPDATE_RIGHT ? i_left : i_left + w_mix;
        n_right = UPDATE_RIGHT ? i_right + w_mix : i_right;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    assign o_valid = r_valid;
    assign o_left  = r_left;
    assign o_right = r_right;

endmodule
`default_nettype wire

>>> design/xtea_block_encipher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XTEA block encipher
// Fully pipelined XTEA encipher, one 64-bit block per clock while the receiver does not stall.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel: i_valid / o_stall with i_plain_left, i_plain_right.
//    A transaction completes on a rising edge with i_valid high and
//    o_stall low.
//  - Output channel: o_valid / i_stall with o_cipher_left, o_cipher_right.
//  - Key: four 32-bit words on the APB port, key_word0..3 at 0x0..0xC.
//    pready is tied high; writes land on the access cycle. Only write the
//    key while the pipeline is empty.
//  - Pipeline: one register per half-round, a chain of 2*ROUNDS
//    half-round stages, each holding one block. Throughput is one block
//    every cycle while the receiver does not stall.
//  - Reset (synchronous, active low) clears all stage valid bits and the
//    key to zero.
//  - Receiver stall: when the last stage holds a block and i_stall is high
//    the whole pipeline freezes and o_stall goes high; nothing is dropped
//    or repeated. Bubbles are not squeezed out while frozen.
// ----------------------------------------------------------------------------
module xtea_block_encipher #(
    parameter int unsigned ROUNDS = xtea_pkg::ROUNDS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire xtea_pkg::t_word               i_plain_left,
    input  wire xtea_pkg::t_word               i_plain_right,
    // output channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output xtea_pkg::t_word                    o_cipher_left,
    output xtea_pkg::t_word                    o_cipher_right,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [xtea_pkg::ADDR_W-1:0]   paddr,
    input  wire xtea_pkg::t_word               pwdata,
    output xtea_pkg::t_word                    prdata,
    output logic                               pready
);

    localparam int unsigned NSTAGE = 2 * ROUNDS;

    // key registers
    xtea_pkg::t_word   r_key [xtea_pkg::KEY_WORDS];
    xtea_pkg::t_reg_idx w_idx;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_idx  = xtea_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < xtea_pkg::KEY_WORDS; i++) begin
                r_key[i] <= '0;
            end
        end else if (w_wr) begin
            r_key[w_idx] <= pwdata;
        end
    end

    always_comb begin
        case (w_idx)
            xtea_pkg::REG_KEY0: prdata = r_key[0];
            xtea_pkg::REG_KEY1: prdata = r_key[1];
            xtea_pkg::REG_KEY2: prdata = r_key[2];
            xtea_pkg::REG_KEY3: prdata = r_key[3];
            default:            prdata = '0;
        endcase
    end

    // pipeline: global advance, frozen only while a finished block waits
    logic            w_adv;
    logic            w_valid [NSTAGE+1];
    xtea_pkg::t_word w_left  [NSTAGE+1];
    xtea_pkg::t_word w_right [NSTAGE+1];

    assign w_adv      = !(w_valid[NSTAGE] && i_stall);
    assign o_stall    = !w_adv;
    assign w_valid[0] = i_valid;
    assign w_left[0]  = i_plain_left;
    assign w_right[0] = i_plain_right;

    for (genvar r = 0; r < ROUNDS; r++) begin : g_round
        localparam xtea_pkg::t_word    SUM_L = xtea_pkg::round_sum(r);
        localparam xtea_pkg::t_word    SUM_R = xtea_pkg::round_sum(r + 1);
        localparam xtea_pkg::t_reg_idx KI_L  = xtea_pkg::left_key_idx(SUM_L);
        localparam xtea_pkg::t_reg_idx KI_R  = xtea_pkg::right_key_idx(SUM_R);

        // left word mixes in key[sum & 3]
        xtea_half_round #(
            .SUM          (SUM_L),
            .UPDATE_RIGHT (1'b0)
        ) u_left (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_valid[2*r]),
            .i_left  (w_left[2*r]),
            .i_right (w_right[2*r]),
            .i_key   (r_key[KI_L]),
            .o_valid (w_valid[2*r+1]),
            .o_left  (w_left[2*r+1]),
            .o_right (w_right[2*r+1])
        );

        // right word mixes in key[(sum >> 11) & 3] with the advanced sum
        xtea_half_round #(
            .SUM          (SUM_R),
            .UPDATE_RIGHT (1'b1)
        ) u_right (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_valid[2*r+1]),
            .i_left  (w_left[2*r+1]),
            .i_right (w_right[2*r+1]),
            .i_key   (r_key[KI_R]),
            .o_valid (w_valid[2*r+2]),
            .o_left  (w_left[2*r+2]),
            .o_right (w_right[2*r+2])
        );
    end

    assign o_valid        = w_valid[NSTAGE];
    assign o_cipher_left  = w_left[NSTAGE];
    assign o_cipher_right = w_right[NSTAGE];

endmodule
`default_nettype wire

>>> design/xtea_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XTEA port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module xtea_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_cipher_left,
    input wire logic [31:0] o_cipher_right,
    input wire logic        pready
);

    // input is held off only while a finished transaction waits
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("o_stall does not follow a waiting result");

    // a stalled input transaction stays offered
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid)
        else $error("input valid dropped while stalled");

    // waiting result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cipher_left)
            && $stable(o_cipher_right))
        else $error("stalled result changed");

    // reset empties the pipeline
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind xtea_block_encipher xtea_chk u_xtea_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_cipher_left  (o_cipher_left),
    .o_cipher_right (o_cipher_right),
    .pready         (pready)
);
`default_nettype wire

>>> test/tb_xtea_block_encipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA block encipher testbench
// Drives plaintext blocks into the pipelined encipher under several key
// settings and handshake idle/stall mixes. An in-bench cipher model
// predicts each result; results are checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_xtea_block_encipher;

    import xtea_pkg::*;

    // a whole 64-bit block, left word first
    typedef struct packed {
        t_word left;
        t_word right;
    } t_block;

    // watchdog: cycles in a row without any accepted transaction
    localparam int unsigned STALL_LIMIT = 4000;
    // drain time after the last expected result, pipeline depth plus margin
    localparam int unsigned SETTLE_CYCLES = 2 * ROUNDS + 8;
    localparam int unsigned PHASES = 6;
    localparam int unsigned BLOCKS_PER_PHASE = 275;
    localparam int unsigned MAX_PRINTS = 100;

    // ------------------------------------------------------------------------
    // Cipher scoreboard: own key copy, XTEA model and queue of expected
    // cipher blocks in acceptance order.
    // ------------------------------------------------------------------------
    class cipher_scoreboard;
        t_word  key[KEY_WORDS];
        t_block cipher_due[$];
        int     errors;

        function new();
            foreach (key[k]) key[k] = '0;
            errors = 0;
        endfunction

        function void set_key(t_reg_idx idx, t_word value);
            key[idx] = value;
        endfunction

        function int pending();
            return cipher_due.size();
        endfunction

        // ROUNDS Feistel rounds; left half uses sum bits 1:0, right half
        // uses sum bits 12:11 after the delta step
        function t_block encipher(t_block plain);
            t_word l;
            t_word r;
            t_word s;
            t_word f;
            l = plain.left;
            r = plain.right;
            s = '0;
            for (int i = 0; i < ROUNDS; i++) begin
                f = ((r << 4) ^ (r >> 5)) + r;
                l = l + (f ^ (s + key[s[1:0]]));
                s = s + DELTA;
                f = ((l << 4) ^ (l >> 5)) + l;
                r = r + (f ^ (s + key[s[SUM_SHIFT +: 2]]));
            end
            return '{left: l, right: r};
        endfunction

        function void note_plain(t_block plain);
            cipher_due.insert(cipher_due.size(), encipher(plain));
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        task check_cipher(t_block got);
            t_block want;
            if (cipher_due.size() == 0) begin
                report($sformatf("unexpected result %h_%h", got.left, got.right));
                return;
            end
            want = cipher_due.pop_front();
            if (got.left !== want.left)
                report($sformatf("cipher_left %h, expected %h", got.left, want.left));
            if (got.right !== want.right)
                report($sformatf("cipher_right %h, expected %h", got.right, want.right));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block signals; every input known from time zero
    // ------------------------------------------------------------------------
    logic   i_clk          = 1'b0;
    logic   i_rst_n        = 1'b0;
    logic   i_valid        = 1'b0;
    logic   o_stall;
    t_word  i_plain_left   = '0;
    t_word  i_plain_right  = '0;
    logic   o_valid;
    logic   i_stall        = 1'b0;
    t_word  o_cipher_left;
    t_word  o_cipher_right;
    logic   psel           = 1'b0;
    logic   penable        = 1'b0;
    logic   pwrite         = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    t_word  pwdata         = '0;
    t_word  prdata;
    logic   pready;

    // idle mix of the current phase, percent per cycle
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned idle_cycles   = 0;

    cipher_scoreboard sb;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    xtea_block_encipher DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_plain_left   (i_plain_left),
        .i_plain_right  (i_plain_right),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_cipher_left  (o_cipher_left),
        .o_cipher_right (o_cipher_right),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // ------------------------------------------------------------------------
    // Receiver: random stall per cycle, driven on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge. An input
    // transaction feeds the model, an output transaction is checked.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_plain('{left: i_plain_left, right: i_plain_right});
            if (o_valid && !i_stall)
                sb.check_cipher('{left: o_cipher_left, right: o_cipher_right});
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog: nothing moved for too long means a hang
    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT)
            @(negedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // one APB write: setup cycle, then access cycle; pready is tied high,
    // so the key word lands at the edge closing the access cycle
    task automatic key_write(t_reg_idx idx, t_word value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_key(idx, value);
    endtask

    task automatic load_key(t_word w0, t_word w1, t_word w2, t_word w3);
        key_write(REG_KEY0, w0);
        key_write(REG_KEY1, w1);
        key_write(REG_KEY2, w2);
        key_write(REG_KEY3, w3);
    endtask

    // present one block after a random idle gap and hold it until taken
    task automatic send_block(t_word left, t_word right);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_plain_left  <= left;
        i_plain_right <= right;
        do @(posedge i_clk); while (o_stall);
    endtask

    // sender stops until every expected block is back, then lets the
    // pipeline settle; key writes are only safe after this
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() > 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // bias towards all-zero and all-one words, otherwise uniform
    function automatic t_word pick_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_block corner[10];
        int unsigned send_mix[PHASES];
        int unsigned stall_mix[PHASES];

        corner = '{
            '{32'h0000_0000, 32'h0000_0000},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF},
            '{32'h0000_0000, 32'hFFFF_FFFF},
            '{32'hFFFF_FFFF, 32'h0000_0000},
            '{32'h8000_0000, 32'h0000_0001},
            '{32'h0000_0001, 32'h8000_0000},
            '{32'hAAAA_AAAA, 32'h5555_5555},
            '{32'h5555_5555, 32'hAAAA_AAAA},
            '{32'h4142_4344, 32'h4546_4748},
            '{32'h0123_4567, 32'h89AB_CDEF}
        };
        // no idling, sender idle, receiver stalling, both lightly, no idling, both heavily
        send_mix  = '{0, 54, 0, 12, 0, 54};
        stall_mix = '{0, 0, 54, 12, 0, 54};

        sb = new();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // corner blocks under the reset (all-zero) key, no key write yet
        foreach (corner[k])
            send_block(corner[k].left, corner[k].right);
        drain();

        // three blocks under the usual published test key
        load_key(32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F);
        send_block(32'h4142_4344, 32'h4546_4748);
        send_block(32'h0000_0000, 32'h0000_0000);
        send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            // a fresh key per phase: extremes first, then random words
            case (p)
                0:       load_key('1, '1, '1, '1);
                1:       load_key('0, '1, '0, '1);
                2:       load_key('1, '0, '1, '0);
                default: load_key(pick_word(), pick_word(), pick_word(), pick_word());
            endcase
            send_idle_pct = send_mix[p];
            stall_pct     = stall_mix[p];
            repeat (BLOCKS_PER_PHASE)
                send_block(pick_word(), pick_word());
            drain();
        end

        send_idle_pct = 0;
        stall_pct     = 0;
        while (sb.pending() > 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
